@@ src/mdcg_pkg.sv @@
// ----------------------------------------------------------------------------
// mdcg_pkg
// Shared widths, register indexes, transfer layouts and stage records for
// the mower drive command gate.
// ----------------------------------------------------------------------------
package mdcg_pkg;

  localparam int VelW     = 16;   // wheel velocity, signed Q8.8
  localparam int GainW    = 24;   // pwm gain, unsigned Q16.8
  localparam int GainFrac = 16;   // fraction bits of velocity times gain
  localparam int PwmW     = 12;   // unsigned pwm magnitude
  localparam int WheelW   = PwmW + 1;
  localparam int EffW     = 12;   // blade effort, signed Q4.8
  localparam int EffFrac  = 8;
  localparam int EffClW   = EffFrac + 1;   // effort clamped to 0..1.0
  localparam int MsW      = 16;
  localparam int IdleW    = 32;
  localparam int TmoW     = 24;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int InDataW  = 64;
  localparam int OutDataW = 40;

  localparam logic [EffClW-1:0] EffOne = EffClW'(1 << EffFrac);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PWM_GAIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PWM      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MOW_PWM      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_FLIP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_FLIP   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TIMEOUT = 3'd5;

  // item kinds carried in tuser
  localparam logic FUNC_CONTROL = 1'b0;
  localparam logic FUNC_STOP    = 1'b1;

  typedef struct packed {
    logic                   active;
    logic                   link_ok;
    logic                   drive_en;
    logic                   emergency;
    logic [MsW-1:0]         elapsed_ms;
    logic signed [EffW-1:0] blade_effort;
    logic signed [VelW-1:0] right_vel;
    logic signed [VelW-1:0] left_vel;
  } in_data_t;

  typedef struct packed {
    logic                     blade_locked;
    logic [PwmW-1:0]          blade_pwm;
    logic signed [WheelW-1:0] right_pwm;
    logic signed [WheelW-1:0] left_pwm;
  } result_t;

  typedef struct packed {
    logic [GainW-1:0] pwm_gain;
    logic [PwmW-1:0]  max_pwm;
    logic [PwmW-1:0]  mow_pwm;
    logic             left_flip;
    logic             right_flip;
    logic [TmoW-1:0]  idle_timeout_ms;
  } cfg_t;

  // item after scaling, ahead of the stateful stage
  typedef struct packed {
    logic                     func;
    logic signed [WheelW-1:0] left_pwm;
    logic signed [WheelW-1:0] right_pwm;
    logic [PwmW-1:0]          blade_raw;
    logic                     eff_le0;
    logic [MsW-1:0]           elapsed_ms;
    logic                     emergency;
    logic                     drive_en;
    logic                     link_ok;
    logic                     active;
  } stage_t;

endpackage

@@ src/mdcg_wheel_scale.sv @@
// ----------------------------------------------------------------------------
// mdcg_wheel_scale
// Wheel velocity to pwm: optional negation, gain multiply, truncation
// toward zero and symmetric clamp to max_pwm.
// ----------------------------------------------------------------------------
module mdcg_wheel_scale (
  input  logic signed [mdcg_pkg::VelW-1:0]   vel_i,
  input  logic                               invert_i,
  input  logic [mdcg_pkg::GainW-1:0]         gain_i,
  input  logic [mdcg_pkg::PwmW-1:0]          max_pwm_i,
  output logic signed [mdcg_pkg::WheelW-1:0] pwm_o
);
  import mdcg_pkg::*;

  localparam int ProdW  = VelW + GainW;
  localparam int WholeW = ProdW - GainFrac;

  logic signed [VelW:0] vel_ext;
  logic signed [VelW:0] vel_dir;
  logic [VelW:0]        vel_abs;
  logic                 neg;
  logic [ProdW-1:0]     prod;
  logic [WholeW-1:0]    whole;
  logic [WholeW-1:0]    limit;
  logic [PwmW-1:0]      clamped;
  logic [WheelW-1:0]    mag_ext;

  assign vel_ext = {vel_i[VelW-1], vel_i};
  assign vel_dir = invert_i ? -vel_ext : vel_ext;
  assign neg     = vel_dir[VelW];
  assign vel_abs = neg ? -vel_dir : vel_dir;

  // magnitude is at most 2^15, so it fits the low VelW bits
  assign prod    = ProdW'(vel_abs[VelW-1:0]) * ProdW'(gain_i);
  assign whole   = prod[ProdW-1:GainFrac];
  assign limit   = WholeW'(max_pwm_i);
  assign clamped = (whole > limit) ? max_pwm_i : whole[PwmW-1:0];
  assign mag_ext = {1'b0, clamped};
  assign pwm_o   = neg ? -mag_ext : mag_ext;

endmodule

@@ src/mower_drive_command_gate_core.sv @@
// ----------------------------------------------------------------------------
// mower_drive_command_gate_core
// Wheel and blade pwm command gate with blade idle timer, lockout latch
// and send-on-change filtering.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata drive command, tuser func
//  m_axis   | out | m_axis_tvalid/tready    | tdata pwm triple and lock flag
//  cfg      | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; a result is registered in s1_q, then out_q.
// Stage one does the wheel and blade multiplies, stage two owns all state
// (idle timer, lockout, last sent triple) and loads the output register.
// A stalled output stops stage two, which in turn backs up the input.
// Reset: lockout set, idle timer and sent triple cleared, registers at
// their documented defaults. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module mower_drive_command_gate_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // drive command, low first: left_vel, right_vel, blade_effort, elapsed_ms,
  //                 emergency, drive_en, link_ok, active
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mdcg_pkg::InDataW-1:0]      s_axis_tdata,
  // func
  input  logic                              s_axis_tuser,
  // result: left_pwm, right_pwm, blade_pwm, blade_locked, zero pad (low first)
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mdcg_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mdcg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mdcg_pkg::CfgDataW-1:0]     cfg_data_i
);
  import mdcg_pkg::*;

  localparam int BladeProdW = EffClW + PwmW;

  cfg_t     cfg_q;
  in_data_t in_data;
  stage_t   s1_d, s1_q;
  logic     s1_valid_q;
  result_t  out_d, out_q;
  logic     out_valid_q, out_valid_d;

  logic     lock_q, lock_d;
  logic [IdleW-1:0] idle_q, idle_d;
  result_t  sent_q, sent_d;
  logic     sent_any_q, sent_any_d;

  logic                   s_xfer;
  logic                   s2_go;
  logic signed [WheelW-1:0] left_pwm, right_pwm;
  logic [EffClW-1:0]      eff_cl;
  logic [BladeProdW-1:0]  blade_prod;
  logic [IdleW:0]         idle_sum;
  logic [IdleW-1:0]       idle_next;
  logic                   is_idle;
  logic                   kill;
  logic                   lock_new;
  result_t                cand;
  logic                   emit;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_gain        <= GainW'(256);
      cfg_q.max_pwm         <= PwmW'(255);
      cfg_q.mow_pwm         <= PwmW'(255);
      cfg_q.left_flip       <= 1'b0;
      cfg_q.right_flip      <= 1'b0;
      cfg_q.idle_timeout_ms <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PWM_GAIN:     cfg_q.pwm_gain        <= cfg_data_i[GainW-1:0];
        CFG_MAX_PWM:      cfg_q.max_pwm         <= cfg_data_i[PwmW-1:0];
        CFG_MOW_PWM:      cfg_q.mow_pwm         <= cfg_data_i[PwmW-1:0];
        CFG_LEFT_FLIP:    cfg_q.left_flip       <= cfg_data_i[0];
        CFG_RIGHT_FLIP:   cfg_q.right_flip      <= cfg_data_i[0];
        CFG_IDLE_TIMEOUT: cfg_q.idle_timeout_ms <= cfg_data_i[TmoW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign in_data = in_data_t'(s_axis_tdata);

  mdcg_wheel_scale u_left (
    .vel_i     (in_data.left_vel),
    .invert_i  (cfg_q.left_flip),
    .gain_i    (cfg_q.pwm_gain),
    .max_pwm_i (cfg_q.max_pwm),
    .pwm_o     (left_pwm)
  );

  mdcg_wheel_scale u_right (
    .vel_i     (in_data.right_vel),
    .invert_i  (cfg_q.right_flip),
    .gain_i    (cfg_q.pwm_gain),
    .max_pwm_i (cfg_q.max_pwm),
    .pwm_o     (right_pwm)
  );

  // effort clamped to 0..1.0 before scaling by mow_pwm
  assign eff_cl = in_data.blade_effort[EffW-1] ? '0 :
                  (in_data.blade_effort[EffW-2:0] > (EffW-1)'(EffOne)) ? EffOne :
                  in_data.blade_effort[EffClW-1:0];
  assign blade_prod = BladeProdW'(eff_cl) * BladeProdW'(cfg_q.mow_pwm);

  always_comb begin
    s1_d.func           = s_axis_tuser;
    s1_d.left_pwm       = left_pwm;
    s1_d.right_pwm      = right_pwm;
    s1_d.blade_raw      = blade_prod[EffFrac +: PwmW];
    s1_d.eff_le0        = in_data.blade_effort[EffW-1] || (in_data.blade_effort == '0);
    s1_d.elapsed_ms     = in_data.elapsed_ms;
    s1_d.emergency      = in_data.emergency;
    s1_d.drive_en       = in_data.drive_en;
    s1_d.link_ok        = in_data.link_ok;
    s1_d.active         = in_data.active;
  end

  assign s2_go         = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s2_go;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s2_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // idle timer counts only while wheels are still and the blade is asked for
  assign idle_sum  = {1'b0, idle_q} + (IdleW + 1)'(s1_q.elapsed_ms);
  assign idle_next = (s1_q.left_pwm != '0 || s1_q.right_pwm != '0 || s1_q.eff_le0) ? '0 :
                     idle_sum[IdleW] ? '1 : idle_sum[IdleW-1:0];
  assign is_idle   = (cfg_q.idle_timeout_ms != '0) &&
                     (idle_next > IdleW'(cfg_q.idle_timeout_ms));
  assign kill      = s1_q.emergency || !s1_q.drive_en || !s1_q.link_ok;
  assign lock_new  = (kill || is_idle) ? 1'b1 : (s1_q.eff_le0 ? 1'b0 : lock_q);

  always_comb begin
    cand.blade_locked = lock_new;
    cand.left_pwm     = kill ? '0 : s1_q.left_pwm;
    cand.right_pwm    = kill ? '0 : s1_q.right_pwm;
    cand.blade_pwm    = (kill || lock_new) ? '0 : s1_q.blade_raw;
  end

  always_comb begin
    lock_d      = lock_q;
    idle_d      = idle_q;
    sent_d      = sent_q;
    sent_any_d  = sent_any_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    emit        = 1'b0;
    if (s2_go) begin
      if (s1_q.func == FUNC_STOP) begin
        lock_d             = 1'b1;
        out_d              = '0;
        out_d.blade_locked = 1'b1;
        emit               = 1'b1;
      end else if (s1_q.active) begin
        lock_d = lock_new;
        idle_d = idle_next;
        out_d  = cand;
        emit   = !sent_any_q || (cand.left_pwm != sent_q.left_pwm) ||
                 (cand.right_pwm != sent_q.right_pwm) ||
                 (cand.blade_pwm != sent_q.blade_pwm);
      end
      if (emit) begin
        sent_d      = out_d;
        sent_any_d  = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        out_d = out_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q      <= 1'b1;
      idle_q      <= '0;
      sent_q      <= '0;
      sent_any_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lock_q      <= lock_d;
      idle_q      <= idle_d;
      sent_q      <= sent_d;
      sent_any_q  <= sent_any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_q);

`ifndef SYNTHESIS
  a_blade_off_when_locked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.blade_pwm != '0) |-> !out_q.blade_locked)
    else $error("blade pwm sent while lockout set");

  a_unlock_needs_blade_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(lock_q) |-> $past(s2_go && s1_q.eff_le0 && (s1_q.func != FUNC_STOP)))
    else $error("lockout released without blade commanded off");

  a_sent_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_any_q |=> sent_any_q)
    else $error("sent record lost");

  a_stop_emits_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_go && (s1_q.func == FUNC_STOP) |=>
      out_valid_q && out_q.blade_locked && (out_q.left_pwm == '0) &&
      (out_q.right_pwm == '0) && (out_q.blade_pwm == '0))
    else $error("forced stop did not produce zero triple");
`endif

endmodule
